[src/bwu_pkg.sv]
// ----------------------------------------------------------------------------
// bwu_pkg: shared types and constants for the barycentric weight unit
// Field widths of the coordinate and weight formats, and the sideband that
// travels beside the division pipeline.
// ----------------------------------------------------------------------------
package bwu_pkg;

  // Coordinate and intermediate widths (fixed by the Q8.8 input format)
  localparam int COORD_W  = 16;  // Q8.8 input coordinate
  localparam int DIFF_W   = 17;  // difference of two coordinates
  localparam int PROD_W   = 34;  // product of two differences
  localparam int CROSS_W  = 35;  // difference of two products
  localparam int MAG_W    = 34;  // magnitude of a cross product
  localparam int WEIGHT_W = 18;  // output weight
  localparam int THRESH_W = 33;  // degenerate threshold register

  // Default number of fractional weight bits
  localparam int WEIGHT_FRAC_BITS_DEF = 14;

  // Configuration register map
  localparam int        CFG_DATA_W = 64;
  localparam int        CFG_ADDR_W = 4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_THRESH = 4'h0;
  localparam logic [THRESH_W-1:0]   THRESH_RST  = 33'd1;

  // Sideband carried along with each item through the divider
  typedef struct packed {
    logic valid;
    logic degen;
    logic neg1;
    logic neg2;
  } side_t;

endpackage

[src/bwu_div.sv]
// ----------------------------------------------------------------------------
// bwu_div: dual-lane pipelined restoring divider
// Two unsigned quotients against a shared divisor, one quotient bit per
// register stage; the sideband moves in step with the data.
// ----------------------------------------------------------------------------
module bwu_div
  import bwu_pkg::*;
#(
  parameter int FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  side_t                      side_in,
  input  logic [MAG_W-1:0]           num1_in,
  input  logic [MAG_W-1:0]           num2_in,
  input  logic [MAG_W-1:0]           den_in,
  output side_t                      side_out,
  output logic [MAG_W+FRAC_BITS-1:0] quo1_out,
  output logic [MAG_W+FRAC_BITS-1:0] quo2_out
);

  localparam int QW = MAG_W + FRAC_BITS;

  // Per-stage registers: index 0 is the loaded item, index QW the result
  side_t            side_r [QW+1];
  logic [QW-1:0]    x1_r   [QW+1];
  logic [QW-1:0]    x2_r   [QW+1];
  logic [MAG_W-1:0] r1_r   [QW+1];
  logic [MAG_W-1:0] r2_r   [QW+1];
  logic [MAG_W-1:0] den_r  [QW+1];

  // Load the scaled numerators with cleared remainders
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0] <= '0;
    end else if (en) begin
      side_r[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r[0]  <= {num1_in, {FRAC_BITS{1'b0}}};
      x2_r[0]  <= {num2_in, {FRAC_BITS{1'b0}}};
      r1_r[0]  <= '0;
      r2_r[0]  <= '0;
      den_r[0] <= den_in;
    end
  end

  // One compare-and-subtract per stage and lane
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [MAG_W:0] t1, t2, d;
    logic           q1, q2;
    logic [MAG_W:0] n1, n2;

    always_comb begin
      d  = {1'b0, den_r[s]};
      t1 = {r1_r[s], x1_r[s][QW-1]};
      t2 = {r2_r[s], x2_r[s][QW-1]};
      q1 = (t1 >= d);
      q2 = (t2 >= d);
      n1 = q1 ? (t1 - d) : t1;
      n2 = q2 ? (t2 - d) : t2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s+1] <= '0;
      end else if (en) begin
        side_r[s+1] <= side_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x1_r[s+1]  <= {x1_r[s][QW-2:0], q1};
        x2_r[s+1]  <= {x2_r[s][QW-2:0], q2};
        r1_r[s+1]  <= n1[MAG_W-1:0];
        r2_r[s+1]  <= n2[MAG_W-1:0];
        den_r[s+1] <= den_r[s];
      end
    end
  end

  assign side_out = side_r[QW];
  assign quo1_out = x1_r[QW];
  assign quo2_out = x2_r[QW];

endmodule

[src/barycentric_weight_unit.sv]
// ----------------------------------------------------------------------------
// barycentric_weight_unit: 2D barycentric weights of a point in a triangle
// Fixed-point cross products, threshold test for degenerate triangles and
// two pipelined divisions giving three saturated Q(17-F).F weights.
//
//  Channel  | Dir | Transfer when             | Contents
//  in_*     | in  | in_tvalid & in_tready     | point, vertices A, B, C (Q8.8)
//  out_*    | out | out_tvalid & out_tready   | weights, inside flag, degenerate
//  cfg_*    | in  | psel&penable&pwrite       | degenerate threshold at 0x0
//
// One item per cycle while out_tready does not hold the pipeline; the
// divider resolves one quotient bit per stage.
// rst_n clears all valid bits and sets the threshold to 1.
// The whole pipeline holds while a result waits on out_tready; nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
module barycentric_weight_unit
  import bwu_pkg::*;
#(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // point_x, point_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
  // vert_c_x, vert_c_y (16 bits each, from bit 0 up)
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [127:0]          in_tdata,
  // weight_a, weight_b, weight_c (18 bits each), inside_res, one zero pad bit
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,
  // degenerate
  output logic                  out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int QW = MAG_W + WEIGHT_FRAC_BITS;
  localparam int WW = QW + 3;
  localparam logic signed [WW-1:0] ONE   = WW'(1) <<< WEIGHT_FRAC_BITS;
  localparam logic signed [WW-1:0] W_MAX = WW'(131071);
  localparam logic signed [WW-1:0] W_MIN = -WW'(131072);
  localparam logic signed [WW-1:0] THIRD_RAW = WW'((64'd1 << WEIGHT_FRAC_BITS) / 3);
  localparam logic [WEIGHT_W-1:0]  THIRD =
    (THIRD_RAW > W_MAX) ? W_MAX[WEIGHT_W-1:0] : THIRD_RAW[WEIGHT_W-1:0];

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Configuration register
  logic [THRESH_W-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_THRESH) begin
      thresh_r <= cfg_pwdata[THRESH_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_THRESH) ? CFG_DATA_W'(thresh_r) : '0;

  // Stage 1: edge and offset vectors
  logic                     v1_r;
  logic signed [DIFF_W-1:0] e0x_r, e0y_r, e1x_r, e1y_r, dx_r, dy_r;

  function automatic logic signed [DIFF_W-1:0] sub16(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
    return DIFF_W'($signed(a)) - DIFF_W'($signed(b));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0x_r <= sub16(in_tdata[79:64],   in_tdata[47:32]);
      e0y_r <= sub16(in_tdata[95:80],   in_tdata[63:48]);
      e1x_r <= sub16(in_tdata[111:96],  in_tdata[47:32]);
      e1y_r <= sub16(in_tdata[127:112], in_tdata[63:48]);
      dx_r  <= sub16(in_tdata[15:0],    in_tdata[47:32]);
      dy_r  <= sub16(in_tdata[31:16],   in_tdata[63:48]);
    end
  end

  // Stage 2: the six products
  logic                     v2_r;
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= e0x_r * e1y_r;
      pb_r <= e1x_r * e0y_r;
      pc_r <= dx_r  * e1y_r;
      pd_r <= e1x_r * dy_r;
      pe_r <= e0x_r * dy_r;
      pf_r <= dx_r  * e0y_r;
    end
  end

  // Stage 3: cross products
  logic                      v3_r;
  logic signed [CROSS_W-1:0] den_r, n1_r, n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= CROSS_W'(pa_r) - CROSS_W'(pb_r);
      n1_r  <= CROSS_W'(pc_r) - CROSS_W'(pd_r);
      n2_r  <= CROSS_W'(pe_r) - CROSS_W'(pf_r);
    end
  end

  // Stage 4: magnitudes, signs and the degenerate test
  side_t            side4_r;
  logic [MAG_W-1:0] dm4_r, m14_r, m24_r;
  logic [CROSS_W-1:0] den_abs, n1_abs, n2_abs;
  logic               degen;

  always_comb begin
    den_abs = den_r[CROSS_W-1] ? -den_r : den_r;
    n1_abs  = n1_r[CROSS_W-1]  ? -n1_r  : n1_r;
    n2_abs  = n2_r[CROSS_W-1]  ? -n2_r  : n2_r;
    degen   = (den_r == '0) || ({1'b0, den_abs} < (CROSS_W+1)'(thresh_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side4_r <= '0;
    end else if (en) begin
      side4_r.valid <= v3_r;
      side4_r.degen <= degen;
      side4_r.neg1  <= n1_r[CROSS_W-1] ^ den_r[CROSS_W-1];
      side4_r.neg2  <= n2_r[CROSS_W-1] ^ den_r[CROSS_W-1];
    end
  end

  // Hold a divisor of one for degenerate items so the divider stays defined
  always_ff @(posedge clk) begin
    if (en) begin
      dm4_r <= degen ? MAG_W'(1) : den_abs[MAG_W-1:0];
      m14_r <= n1_abs[MAG_W-1:0];
      m24_r <= n2_abs[MAG_W-1:0];
    end
  end

  // Divider stages
  side_t         side_q;
  logic [QW-1:0] q1, q2;

  bwu_div #(
    .FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .side_in  (side4_r),
    .num1_in  (m14_r),
    .num2_in  (m24_r),
    .den_in   (dm4_r),
    .side_out (side_q),
    .quo1_out (q1),
    .quo2_out (q2)
  );

  // Stage 5: signed weights
  logic                     v5_r, dg5_r;
  logic signed [WW-1:0]     w1_r, w2_r;
  logic signed [WW-1:0]     w1s, w2s;

  always_comb begin
    w1s = side_q.neg1 ? -$signed(WW'(q1)) : $signed(WW'(q1));
    w2s = side_q.neg2 ? -$signed(WW'(q2)) : $signed(WW'(q2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= side_q.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg5_r <= side_q.degen;
      w1_r  <= w1s;
      w2_r  <= w2s;
    end
  end

  // Stage 6: third weight, saturation, inside test
  logic                    out_valid_r;
  logic [55:0]             out_data_r;
  logic                    out_degen_r;
  logic signed [WW-1:0]    w0;
  logic [WEIGHT_W-1:0]     s0, s1, s2;
  logic                    in_tri;

  function automatic logic [WEIGHT_W-1:0] sat(input logic signed [WW-1:0] w);
    logic [WEIGHT_W-1:0] r;
    if (w > W_MAX) begin
      r = W_MAX[WEIGHT_W-1:0];
    end else if (w < W_MIN) begin
      r = W_MIN[WEIGHT_W-1:0];
    end else begin
      r = w[WEIGHT_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    w0     = ONE - w1_r - w2_r;
    in_tri = (w0 >= 0) && (w0 <= ONE) && (w1_r >= 0) && (w1_r <= ONE) &&
             (w2_r >= 0) && (w2_r <= ONE);
    s0     = sat(w0);
    s1     = sat(w1_r);
    s2     = sat(w2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_degen_r <= dg5_r;
      out_data_r  <= dg5_r ? {2'b00, THIRD, THIRD, THIRD}
                           : {1'b0, in_tri, s2, s1, s0};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_degen_r;

endmodule

[tb/sv/barycentric_weight_unit_test.sv]
// ----------------------------------------------------------------------------
// barycentric_weight_unit_test: self-checking bench for the weight unit
// A queue of triangles and query points is streamed into the unit while the
// result side stalls at random. Every result is compared field by field with
// weights computed here from the same coordinates and the current threshold.
// ----------------------------------------------------------------------------
module barycentric_weight_unit_test;
  import bwu_pkg::*;

  localparam int FRAC      = WEIGHT_FRAC_BITS_DEF;
  localparam int LATENCY   = 7 + 34 + FRAC;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1250;

  typedef struct packed {
    logic signed [15:0] cy, cx, by, bx, ay, ax, py, px;
  } tri_item_t;

  typedef struct packed {
    logic               degen;
    logic               in_tri;
    logic signed [17:0] wc, wb, wa;
  } weights_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [127:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [55:0] out_tdata;
  logic out_tuser;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  barycentric_weight_unit DUT (.*);

  tri_item_t   pending_items[$];
  weights_t    expected_weights[$];
  logic [32:0] threshold;
  int          send_idle_pct, recv_stall_pct, hold_off;
  int          mismatches, watchdog;
  bit          timed_out;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [17:0] clamp_weight(longint w);
    if (w > 131071) return 18'sd131071;
    if (w < -131072) return -18'sd131072;
    return w[17:0];
  endfunction

  // Exact weights of the point, in 64-bit arithmetic
  function automatic weights_t compute_weights(tri_item_t t, logic [32:0] thr);
    longint one, e0x, e0y, e1x, e1y, dx, dy, den, mag, n1, n2, w0, w1, w2;
    weights_t r;
    one = longint'(1) << FRAC;
    e0x = longint'(t.bx) - t.ax; e0y = longint'(t.by) - t.ay;
    e1x = longint'(t.cx) - t.ax; e1y = longint'(t.cy) - t.ay;
    dx  = longint'(t.px) - t.ax; dy  = longint'(t.py) - t.ay;
    den = e0x * e1y - e1x * e0y;
    mag = den < 0 ? -den : den;
    if (den == 0 || mag < longint'({31'd0, thr})) begin
      r.wa = clamp_weight(one / 3); r.wb = r.wa; r.wc = r.wa;
      r.in_tri = 1'b0; r.degen = 1'b1;
      return r;
    end
    n1 = dx * e1y - e1x * dy;
    n2 = e0x * dy - dx * e0y;
    w1 = (n1 * one) / den;
    w2 = (n2 * one) / den;
    w0 = one - w1 - w2;
    r.wa = clamp_weight(w0); r.wb = clamp_weight(w1); r.wc = clamp_weight(w2);
    r.in_tri = (w0 >= 0 && w0 <= one) && (w1 >= 0 && w1 <= one) &&
               (w2 >= 0 && w2 <= one);
    r.degen = 1'b0;
    return r;
  endfunction

  // Drive: offer the head of the queue, advance on transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_weights.push_back(compute_weights(in_tdata, threshold));
        void'(pending_items.pop_front());
      end
      if ((!in_tvalid || in_tready) || !in_tvalid) begin
        if (in_tvalid && !in_tready) begin
          // hold the offered item
        end else if (pending_items.size() > (in_tvalid && in_tready ? 0 : 0) &&
                     !(in_tvalid && in_tready && pending_items.size() == 0) &&
                     $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= pending_items.size() != 0;
          if (pending_items.size() != 0) in_tdata <= pending_items[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receive: random stall or long hold-off, check each result
  always @(posedge clk) begin
    weights_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[54:0]};
        if (expected_weights.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_weights.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: wa %0d/%0d wb %0d/%0d wc %0d/%0d in %b/%b dg %b/%b",
                       want.wa, got.wa, want.wb, got.wb, want.wc, got.wc,
                       want.in_tri, got.in_tri, want.degen, got.degen);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      watchdog <= 0;
    end else if (!timed_out && watchdog + 1 >= WDOG_MAX) begin
      timed_out = 1'b1;
      $display("barycentric_weight_unit_test: FAIL");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  task automatic write_threshold(logic [32:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= ADDR_THRESH;
    cfg_pwdata <= {31'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    threshold = value;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_tvalid || expected_weights.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(int span);
    if (span == 0) return 16'($urandom());
    return $signed(16'($urandom_range(2 * span))) - 16'(span);
  endfunction

  task automatic add_item(tri_item_t t);
    pending_items.push_back(t);
  endtask

  task automatic add_random(int n);
    tri_item_t t;
    int span;
    t = '0;
    repeat (n) begin
      span = ($urandom_range(3) == 0) ? 0 : ($urandom_range(1) ? 2048 : 300);
      t.ax = rand_coord(span); t.ay = rand_coord(span);
      t.bx = rand_coord(span); t.by = rand_coord(span);
      t.cx = rand_coord(span); t.cy = rand_coord(span);
      case ($urandom_range(5))
        0: begin t.cx = t.bx; t.cy = t.by; end           // collapsed edge
        1: begin t.px = t.ax; t.py = t.ay; end           // point on vertex
        2: begin t.cx = t.bx + t.bx - t.ax; t.cy = t.by + t.by - t.ay; end
        default: begin t.px = rand_coord(span); t.py = rand_coord(span); end
      endcase
      if ($urandom_range(3) == 0) begin
        // point between the vertices, usually inside
        t.px = (t.ax + t.bx + t.cx) / 3; t.py = (t.ay + t.by + t.cy) / 3;
      end
      add_item(t);
    end
  endtask

  initial begin
    tri_item_t t;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    threshold = 33'd1;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    mismatches = 0; watchdog = 0; timed_out = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unit triangle, corners, extremes, zero area, huge weights
    t = '{cy:16'sd256, cx:16'sd0, by:16'sd0, bx:16'sd256, ay:16'sd0, ax:16'sd0,
          py:16'sd64, px:16'sd64};
    add_item(t);
    t.px = 0; t.py = 0; add_item(t);
    t.px = 256; t.py = 0; add_item(t);
    t.px = 0; t.py = 256; add_item(t);
    t.px = 128; t.py = 128; add_item(t);
    t.px = -32768; t.py = 32767; add_item(t);
    t = '{cy:16'sd32767, cx:-16'sd32768, by:-16'sd32768, bx:16'sd32767,
          ay:-16'sd32768, ax:-16'sd32768, py:16'sd0, px:16'sd0};
    add_item(t);
    t = '{cy:16'sd1, cx:16'sd0, by:16'sd0, bx:16'sd1, ay:16'sd0, ax:16'sd0,
          py:16'sd32767, px:-16'sd32768};
    add_item(t);
    t = '{default:16'sd100}; add_item(t);
    t = '{cy:16'sd3, cx:16'sd3, by:16'sd2, bx:16'sd2, ay:16'sd1, ax:16'sd1,
          py:16'sd5, px:16'sd0};
    add_item(t);
    t = '{default:-16'sd32768}; t.by = 16'sd32767; t.cx = 16'sd32767;
    add_item(t);
    t = '{default:16'sd0}; t.px = -1; t.py = -1; t.bx = 16'sd32767; t.cy = 16'sd32767;
    add_item(t);
    wait_drained();

    // Threshold extremes and midpoints, each with a traffic pattern chosen by ph % 4
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_threshold(33'd0);
        1: write_threshold(33'h1_FFFF_FFFF);
        2: write_threshold(33'd65536);
        3: write_threshold(33'($urandom()));
        4: write_threshold(33'h1_0000_0000);
        default: write_threshold(33'd1);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      add_random(ph == 1 ? 40 : N_RANDOM / 5);
      if (ph == 2) hold_off = 400;
      wait_drained();
    end

    if (mismatches == 0 && expected_weights.size() == 0)
      $display("barycentric_weight_unit_test: PASS");
    else
      $display("barycentric_weight_unit_test: FAIL");
    $finish;
  end

endmodule
